FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the PID controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is low.
`define PCF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcf_checker: assertion failed");

// Concurrent assertion on the rising clock edge that also holds during reset.
`define PCF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pcf_checker: assertion failed");

`endif

FILE: design/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Types, codes and default widths shared by the three-form PID controller.
// ----------------------------------------------------------------------------
package pcf_pkg;

    // Default widths of the sample, the drive and the gain fraction.
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_DRIVE_WIDTH  = 32;
    localparam int DEF_FRAC_BITS    = 8;

    // Gains are fixed 16-bit signed values.
    localparam int GAIN_W = 16;

    // Register map.
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KP        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KI        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KD        = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_MAX = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_MIN = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_MAX = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_MIN = 3'd7;

    // Controller form selected per sample.
    typedef enum logic [1:0] {
        OP_INCREMENTAL = 2'd0,
        OP_POSITIONAL  = 2'd1,
        OP_SERIES      = 2'd2,
        OP_HOLD        = 2'd3
    } t_op;

    // Gain fed to the shared multiplier.
    typedef enum logic [1:0] {
        GS_KP,
        GS_KI,
        GS_KD
    } t_gain_sel;

    // Operand fed to the shared multiplier.
    typedef enum logic [2:0] {
        OS_ERR,
        OS_DIFF1,
        OS_DIFF2,
        OS_ESUM,
        OS_ACC
    } t_opnd_sel;

    // Accumulator update.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_DRIVE,
        ACC_ADD,
        ACC_INTEG,
        ACC_SAT
    } t_acc_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      esum_upd;
        logic      mul_en;
        t_gain_sel gain_sel;
        t_opnd_sel opnd_sel;
        t_acc_op   acc_op;
        logic      integ_add_e;
        logic      finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic out_free;
    } t_dp_status;

endpackage

FILE: design/pid_controller_three_forms.sv
// ----------------------------------------------------------------------------
// pid_controller_three_forms
// Fixed-point PID controller in incremental, positional or series form,
// chosen per sample, with configuration registers on an APB-style port.
//
// Channel    Direction  Contents
// s_axis     in         tdata: measurement; tuser: operation
// m_axis     out        tdata: drive
// apb        in/out     setpoint, kp, ki, kd, drive and integral limits
//
// An item passes through the sequencer in steps: the transfer cycle, one
// dispatch step, one step per multiply or add on the shared multiplier and
// accumulator, and a final step that writes the result register. The hold
// code goes from the dispatch step straight to the final step.
// The next sample is taken in the cycle after its result is registered, also
// while that result still waits on m_axis.
// A result that is still unclaimed stalls the next one in its final step.
// Reset is synchronous; it zeroes history, setpoint and gains and opens all
// limits to the full range.
// ----------------------------------------------------------------------------
module pid_controller_three_forms
    import pcf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int DRIVE_WIDTH  = DEF_DRIVE_WIDTH,
    parameter int FRAC_BITS    = DEF_FRAC_BITS,
    localparam int DATA_W      = (DRIVE_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB    = (DRIVE_WIDTH > 32) ? 3 : 2,
    localparam int PADDR_W     = ADDR_LSB + REG_IDX_W,
    localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((DRIVE_WIDTH + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // measurement
    input  logic [1:0]             s_axis_tuser,   // operation
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // drive
);

    logic signed [SAMPLE_WIDTH-1:0] w_setpoint;
    logic signed [GAIN_W-1:0]       w_kp;
    logic signed [GAIN_W-1:0]       w_ki;
    logic signed [GAIN_W-1:0]       w_kd;
    logic signed [DRIVE_WIDTH-1:0]  w_drive_max;
    logic signed [DRIVE_WIDTH-1:0]  w_drive_min;
    logic signed [DRIVE_WIDTH-1:0]  w_integ_max;
    logic signed [DRIVE_WIDTH-1:0]  w_integ_min;
    logic [DRIVE_WIDTH-1:0]         w_drive;
    t_dp_cmd                        w_cmd;
    t_dp_status                     w_status;

    assign pready       = 1'b1;
    assign m_axis_tdata = OUT_TDATA_W'(w_drive);

    // Configuration registers.
    pcf_regs #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DRIVE_WIDTH  (DRIVE_WIDTH),
        .DATA_W       (DATA_W),
        .ADDR_LSB     (ADDR_LSB)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_prdata    (prdata),
        .o_setpoint  (w_setpoint),
        .o_kp        (w_kp),
        .o_ki        (w_ki),
        .o_kd        (w_kd),
        .o_drive_max (w_drive_max),
        .o_drive_min (w_drive_min),
        .o_integ_max (w_integ_max),
        .o_integ_min (w_integ_min)
    );

    // Step sequencer.
    pcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and result register.
    pcf_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DRIVE_WIDTH  (DRIVE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_setpoint  (w_setpoint),
        .i_kp        (w_kp),
        .i_ki        (w_ki),
        .i_kd        (w_kd),
        .i_drive_max (w_drive_max),
        .i_drive_min (w_drive_min),
        .i_integ_max (w_integ_max),
        .i_integ_min (w_integ_min),
        .i_meas      (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_op        (s_axis_tuser),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_drive     (w_drive)
    );

endmodule

FILE: design/pcf_regs.sv
// ----------------------------------------------------------------------------
// pcf_regs
// APB-style configuration registers: setpoint, gains and clamp limits.
// ----------------------------------------------------------------------------
module pcf_regs
    import pcf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int DRIVE_WIDTH  = DEF_DRIVE_WIDTH,
    parameter int DATA_W       = 32,
    parameter int ADDR_LSB     = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [ADDR_LSB+REG_IDX_W-1:0]  i_paddr,
    input  logic [DATA_W-1:0]              i_pwdata,
    output logic [DATA_W-1:0]              o_prdata,
    output logic signed [SAMPLE_WIDTH-1:0] o_setpoint,
    output logic signed [GAIN_W-1:0]       o_kp,
    output logic signed [GAIN_W-1:0]       o_ki,
    output logic signed [GAIN_W-1:0]       o_kd,
    output logic signed [DRIVE_WIDTH-1:0]  o_drive_max,
    output logic signed [DRIVE_WIDTH-1:0]  o_drive_min,
    output logic signed [DRIVE_WIDTH-1:0]  o_integ_max,
    output logic signed [DRIVE_WIDTH-1:0]  o_integ_min
);

    localparam logic signed [DRIVE_WIDTH-1:0] DMAX = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
    localparam logic signed [DRIVE_WIDTH-1:0] DMIN = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] r_setpoint;
    logic signed [GAIN_W-1:0]       r_kp;
    logic signed [GAIN_W-1:0]       r_ki;
    logic signed [GAIN_W-1:0]       r_kd;
    logic signed [DRIVE_WIDTH-1:0]  r_drive_max;
    logic signed [DRIVE_WIDTH-1:0]  r_drive_min;
    logic signed [DRIVE_WIDTH-1:0]  r_integ_max;
    logic signed [DRIVE_WIDTH-1:0]  r_integ_min;
    logic [REG_IDX_W-1:0]           w_idx;
    logic                           w_wr;

    assign w_idx = i_paddr[ADDR_LSB+REG_IDX_W-1:ADDR_LSB];
    assign w_wr  = i_psel & i_penable & i_pwrite;

    // Register writes complete in the access cycle of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= '0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_drive_max <= DMAX;
            r_drive_min <= DMIN;
            r_integ_max <= DMAX;
            r_integ_min <= DMIN;
        end else if (w_wr) begin
            case (w_idx)
                REG_SETPOINT:  r_setpoint  <= $signed(i_pwdata[SAMPLE_WIDTH-1:0]);
                REG_KP:        r_kp        <= $signed(i_pwdata[GAIN_W-1:0]);
                REG_KI:        r_ki        <= $signed(i_pwdata[GAIN_W-1:0]);
                REG_KD:        r_kd        <= $signed(i_pwdata[GAIN_W-1:0]);
                REG_DRIVE_MAX: r_drive_max <= $signed(i_pwdata[DRIVE_WIDTH-1:0]);
                REG_DRIVE_MIN: r_drive_min <= $signed(i_pwdata[DRIVE_WIDTH-1:0]);
                REG_INTEG_MAX: r_integ_max <= $signed(i_pwdata[DRIVE_WIDTH-1:0]);
                REG_INTEG_MIN: r_integ_min <= $signed(i_pwdata[DRIVE_WIDTH-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Read data is the raw register contents, zero extended.
    always_comb begin
        case (w_idx)
            REG_SETPOINT:  o_prdata = DATA_W'($unsigned(r_setpoint));
            REG_KP:        o_prdata = DATA_W'($unsigned(r_kp));
            REG_KI:        o_prdata = DATA_W'($unsigned(r_ki));
            REG_KD:        o_prdata = DATA_W'($unsigned(r_kd));
            REG_DRIVE_MAX: o_prdata = DATA_W'($unsigned(r_drive_max));
            REG_DRIVE_MIN: o_prdata = DATA_W'($unsigned(r_drive_min));
            REG_INTEG_MAX: o_prdata = DATA_W'($unsigned(r_integ_max));
            REG_INTEG_MIN: o_prdata = DATA_W'($unsigned(r_integ_min));
            default:       o_prdata = '0;
        endcase
    end

    assign o_setpoint  = r_setpoint;
    assign o_kp        = r_kp;
    assign o_ki        = r_ki;
    assign o_kd        = r_kd;
    assign o_drive_max = r_drive_max;
    assign o_drive_min = r_drive_min;
    assign o_integ_max = r_integ_max;
    assign o_integ_min = r_integ_min;

endmodule

FILE: design/pcf_ctrl.sv
// ----------------------------------------------------------------------------
// pcf_ctrl
// Sequencer that steps the shared multiplier and accumulator for each form.
// ----------------------------------------------------------------------------
module pcf_ctrl
    import pcf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INC_ADD1,
        S_INC_ADD2,
        S_INC_ADD3,
        S_INT_MUL,
        S_INT_CLAMP,
        S_POS_ADD1,
        S_POS_ADD2,
        S_SER_ADD,
        S_SER_SAT,
        S_SER_MULP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands for each step.
    always_comb begin
        n_state            = r_state;
        o_cmd.load         = 1'b0;
        o_cmd.esum_upd     = 1'b0;
        o_cmd.mul_en       = 1'b0;
        o_cmd.gain_sel     = GS_KP;
        o_cmd.opnd_sel     = OS_ERR;
        o_cmd.acc_op       = ACC_HOLD;
        o_cmd.integ_add_e  = 1'b0;
        o_cmd.finish       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.op == OP_INCREMENTAL) begin
                    o_cmd.acc_op   = ACC_DRIVE;
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.gain_sel = GS_KP;
                    o_cmd.opnd_sel = OS_DIFF1;
                    n_state        = S_INC_ADD1;
                end else if (i_status.op inside {OP_POSITIONAL, OP_SERIES}) begin
                    o_cmd.esum_upd = 1'b1;
                    n_state        = S_INT_MUL;
                end else begin
                    n_state        = S_FINISH;
                end
            end
            S_INC_ADD1: begin
                o_cmd.acc_op   = ACC_ADD;
                o_cmd.mul_en   = 1'b1;
                o_cmd.gain_sel = GS_KI;
                o_cmd.opnd_sel = OS_ERR;
                n_state        = S_INC_ADD2;
            end
            S_INC_ADD2: begin
                o_cmd.acc_op   = ACC_ADD;
                o_cmd.mul_en   = 1'b1;
                o_cmd.gain_sel = GS_KD;
                o_cmd.opnd_sel = OS_DIFF2;
                n_state        = S_INC_ADD3;
            end
            S_INC_ADD3: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_FINISH;
            end
            S_INT_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.gain_sel = GS_KI;
                o_cmd.opnd_sel = OS_ESUM;
                n_state        = S_INT_CLAMP;
            end
            S_INT_CLAMP: begin
                o_cmd.acc_op = ACC_INTEG;
                o_cmd.mul_en = 1'b1;
                if (i_status.op == OP_SERIES) begin
                    // Series form starts the inner sum with the error.
                    o_cmd.integ_add_e = 1'b1;
                    o_cmd.gain_sel    = GS_KD;
                    o_cmd.opnd_sel    = OS_DIFF1;
                    n_state           = S_SER_ADD;
                end else begin
                    o_cmd.gain_sel = GS_KP;
                    o_cmd.opnd_sel = OS_ERR;
                    n_state        = S_POS_ADD1;
                end
            end
            S_POS_ADD1: begin
                o_cmd.acc_op   = ACC_ADD;
                o_cmd.mul_en   = 1'b1;
                o_cmd.gain_sel = GS_KD;
                o_cmd.opnd_sel = OS_DIFF1;
                n_state        = S_POS_ADD2;
            end
            S_POS_ADD2: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_FINISH;
            end
            S_SER_ADD: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_SER_SAT;
            end
            S_SER_SAT: begin
                o_cmd.acc_op = ACC_SAT;
                n_state      = S_SER_MULP;
            end
            S_SER_MULP: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.gain_sel = GS_KP;
                o_cmd.opnd_sel = OS_ACC;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                // Wait here while the previous result is still unclaimed.
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/pcf_dp.sv
// ----------------------------------------------------------------------------
// pcf_dp
// Datapath: error terms, saturating error sum, shared gain multiplier,
// accumulator with clamps, controller state and the output register.
// ----------------------------------------------------------------------------
module pcf_dp
    import pcf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int DRIVE_WIDTH  = DEF_DRIVE_WIDTH,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    output t_dp_status                     o_status,
    input  logic signed [SAMPLE_WIDTH-1:0] i_setpoint,
    input  logic signed [GAIN_W-1:0]       i_kp,
    input  logic signed [GAIN_W-1:0]       i_ki,
    input  logic signed [GAIN_W-1:0]       i_kd,
    input  logic signed [DRIVE_WIDTH-1:0]  i_drive_max,
    input  logic signed [DRIVE_WIDTH-1:0]  i_drive_min,
    input  logic signed [DRIVE_WIDTH-1:0]  i_integ_max,
    input  logic signed [DRIVE_WIDTH-1:0]  i_integ_min,
    input  logic [SAMPLE_WIDTH-1:0]        i_meas,
    input  logic [1:0]                     i_op,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [DRIVE_WIDTH-1:0]         o_drive
);

    // Error, multiplier operand, product, accumulator and error-sum adder widths.
    localparam int EW    = SAMPLE_WIDTH + 1;
    localparam int OPW   = (DRIVE_WIDTH > SAMPLE_WIDTH + 3) ? DRIVE_WIDTH : SAMPLE_WIDTH + 3;
    localparam int PW    = OPW + GAIN_W;
    localparam int ACC_W = PW + 2;
    localparam int SW    = ((DRIVE_WIDTH > EW) ? DRIVE_WIDTH : EW) + 1;

    localparam logic signed [DRIVE_WIDTH-1:0] DMAX = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
    localparam logic signed [DRIVE_WIDTH-1:0] DMIN = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};

    t_op                          r_op;
    logic signed [EW-1:0]         r_err;
    logic signed [EW-1:0]         r_last_err;
    logic signed [EW-1:0]         r_prev_err;
    logic signed [DRIVE_WIDTH-1:0] r_esum;
    logic signed [DRIVE_WIDTH-1:0] r_last_drive;
    logic signed [PW-1:0]         r_prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic                         r_out_valid;
    logic [DRIVE_WIDTH-1:0]       r_out_drive;

    logic signed [EW-1:0]          w_err_new;
    logic signed [OPW-1:0]         w_diff1;
    logic signed [OPW-1:0]         w_diff2;
    logic signed [OPW-1:0]         w_opnd;
    logic signed [GAIN_W-1:0]      w_gain;
    logic signed [PW-1:0]          w_mul;
    logic signed [ACC_W-1:0]       w_prod_sh;
    logic signed [ACC_W-1:0]       w_integ;
    logic signed [ACC_W-1:0]       w_acc_sat;
    logic signed [SW-1:0]          w_esum_raw;
    logic signed [DRIVE_WIDTH-1:0] w_esum_sat;
    logic signed [ACC_W-1:0]       w_res;
    logic signed [ACC_W-1:0]       w_res_clamp;
    logic signed [DRIVE_WIDTH-1:0] w_res_drv;

    // Error of the incoming sample against the setpoint.
    assign w_err_new = EW'(i_setpoint) - EW'($signed(i_meas));

    // First and second differences of the error.
    assign w_diff1 = OPW'(r_err) - OPW'(r_last_err);
    assign w_diff2 = OPW'(r_err) - (OPW'(r_last_err) <<< 1) + OPW'(r_prev_err);

    // Multiplier operand and gain selection.
    always_comb begin
        case (i_cmd.opnd_sel)
            OS_ERR:   w_opnd = OPW'(r_err);
            OS_DIFF1: w_opnd = w_diff1;
            OS_DIFF2: w_opnd = w_diff2;
            OS_ESUM:  w_opnd = OPW'(r_esum);
            OS_ACC:   w_opnd = OPW'($signed(r_acc[DRIVE_WIDTH-1:0]));
            default:  w_opnd = OPW'(r_err);
        endcase
        case (i_cmd.gain_sel)
            GS_KP:   w_gain = i_kp;
            GS_KI:   w_gain = i_ki;
            GS_KD:   w_gain = i_kd;
            default: w_gain = i_kp;
        endcase
    end

    assign w_mul = w_gain * w_opnd;

    // Product scaled back by the gain fraction, rounding toward minus infinity.
    assign w_prod_sh = ACC_W'(r_prod >>> FRAC_BITS);

    // Integral term clamp, upper limit tested first.
    always_comb begin
        if (w_prod_sh > ACC_W'(i_integ_max)) begin
            w_integ = ACC_W'(i_integ_max);
        end else if (w_prod_sh < ACC_W'(i_integ_min)) begin
            w_integ = ACC_W'(i_integ_min);
        end else begin
            w_integ = w_prod_sh;
        end
    end

    // Saturation of the series inner sum to the drive range.
    always_comb begin
        if (r_acc > ACC_W'(DMAX)) begin
            w_acc_sat = ACC_W'(DMAX);
        end else if (r_acc < ACC_W'(DMIN)) begin
            w_acc_sat = ACC_W'(DMIN);
        end else begin
            w_acc_sat = r_acc;
        end
    end

    // Saturating error sum.
    assign w_esum_raw = SW'(r_esum) + SW'(r_err);
    always_comb begin
        if (w_esum_raw > SW'(DMAX)) begin
            w_esum_sat = DMAX;
        end else if (w_esum_raw < SW'(DMIN)) begin
            w_esum_sat = DMIN;
        end else begin
            w_esum_sat = w_esum_raw[DRIVE_WIDTH-1:0];
        end
    end

    // Final drive: series form takes the last product, incremental and positional the sum.
    assign w_res = (r_op == OP_SERIES) ? w_prod_sh : r_acc;
    always_comb begin
        if (w_res > ACC_W'(i_drive_max)) begin
            w_res_clamp = ACC_W'(i_drive_max);
        end else if (w_res < ACC_W'(i_drive_min)) begin
            w_res_clamp = ACC_W'(i_drive_min);
        end else begin
            w_res_clamp = w_res;
        end
    end
    assign w_res_drv = w_res_clamp[DRIVE_WIDTH-1:0];

    // Working registers of one sample.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_op);
            r_err <= w_err_new;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul;
        end
        case (i_cmd.acc_op)
            ACC_DRIVE: r_acc <= ACC_W'(r_last_drive);
            ACC_ADD:   r_acc <= r_acc + w_prod_sh;
            ACC_INTEG: begin
                if (i_cmd.integ_add_e) begin
                    r_acc <= w_integ + ACC_W'(r_err);
                end else begin
                    r_acc <= w_integ;
                end
            end
            ACC_SAT:   r_acc <= w_acc_sat;
            default: begin
            end
        endcase
        if (i_cmd.finish) begin
            if (r_op == OP_HOLD) begin
                r_out_drive <= r_last_drive;
            end else begin
                r_out_drive <= w_res_drv;
            end
        end
    end

    // Controller history and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err   <= '0;
            r_prev_err   <= '0;
            r_esum       <= '0;
            r_last_drive <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.esum_upd) begin
                r_esum <= w_esum_sat;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (r_op != OP_HOLD) begin
                    r_prev_err   <= r_last_err;
                    r_last_err   <= r_err;
                    r_last_drive <= w_res_drv;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.op       = r_op;
    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_drive           = r_out_drive;

endmodule

FILE: design/pcf_checker.sv
// ----------------------------------------------------------------------------
// pcf_checker
// Port-level checks of the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcf_checker
    import pcf_pkg::*;
#(
    parameter int DRIVE_WIDTH  = DEF_DRIVE_WIDTH,
    localparam int OUT_TDATA_W = ((DRIVE_WIDTH + 7) / 8) * 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result stays offered and unchanged.
    `PCF_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `PCF_ASSERT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))

    // Reset empties the result register.
    `PCF_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // One sample at a time: after an input transfer the port closes.
    `PCF_ASSERT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // A new result only appears from a busy sequencer.
    `PCF_ASSERT(a_res_busy, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> !$past(s_axis_tready))

endmodule

bind pid_controller_three_forms pcf_checker #(
    .DRIVE_WIDTH  (DRIVE_WIDTH)
) u_pcf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
